// ===== sv/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/lrc_pkg.sv =====
// shared types and constants for the lru result cache
package lrc_pkg;
   localparam int Entries = 64;
   localparam int IdxBits = $clog2(Entries);
   localparam int OccBits = $clog2(Entries + 1);
   localparam int KeyBits = 32;

   typedef enum logic [1:0] {
      CMD_GET = 2'd0,
      CMD_PUT = 2'd1,
      CMD_INV = 2'd2,
      CMD_CLR = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] query_key;
      logic [15:0] requested_k;
      logic [31:0] store_handle;
      logic [15:0] store_count;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_handle;
      logic [15:0] found_count;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [6:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic start;
   } ctl_type;

   typedef struct packed {
      logic done;
   } sts_type;
endpackage

// ===== sv/lrc_ctrl.sv =====
// controller: accepts a request, runs the datapath, holds the response
module lrc_ctrl import lrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl,
   input  sts_type sts
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = (state_ff == ST_RESP);
   assign ctl.start = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: if (sts.done) state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== sv/lrc_dpath.sv =====
// datapath: entry registers, parallel match, rank update and counters
module lrc_dpath import lrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [6:0] csr_data,
   input  req_type    req_data,
   input  ctl_type    ctl,
   output sts_type    sts,
   output rsp_type    rsp_data
);
   logic [Entries-1:0]      valid_ff, valid_in, stale_ff, stale_in;
   logic [KeyBits-1:0]      key_ff [Entries];
   logic [15:0]             k_ff [Entries];
   logic [31:0]             handle_ff [Entries];
   logic [15:0]             count_ff [Entries];
   logic [IdxBits-1:0]      rank_ff [Entries];
   logic [IdxBits-1:0]      rank_in [Entries];
   logic [31:0]             hits_ff, hits_in, miss_ff, miss_in;
   logic [6:0]              cap_ff;
   logic [OccBits-1:0]      occ_ff, occ_in;
   req_type                 rq_ff;
   logic                    cmp_ff, busy_ff;
   rsp_type                 rsp_ff, rsp_in;

   // stage registers for the match
   logic [Entries-1:0]      match_ff, lru_ff;
   logic [15:0]             rd_k_ff;
   logic [31:0]             rd_handle_ff;
   logic [15:0]             rd_count_ff;
   logic [IdxBits-1:0]      rd_rank_ff;

   logic [Entries-1:0]      match_c, lru_c;
   logic [KeyBits-1:0]      qkey;
   logic [OccBits-1:0]      cap_eff;

   assign qkey    = rq_ff.query_key[KeyBits-1:0];
   assign cap_eff = (cap_ff > 7'(Entries)) ? OccBits'(Entries) : OccBits'(cap_ff);

   always_comb begin
      for (int i = 0; i < Entries; i++) begin
         match_c[i] = valid_ff[i] && (key_ff[i] == qkey);
         lru_c[i]   = valid_ff[i] && ({1'b0, rank_ff[i]} == occ_ff - OccBits'(1));
      end
   end

   // encode helper: index of the lowest set bit
   function automatic logic [IdxBits-1:0] enc(input logic [Entries-1:0] v);
      logic [IdxBits-1:0] r;
      r = '0;
      for (int i = Entries - 1; i >= 0; i--) if (v[i]) r = IdxBits'(i);
      return r;
   endfunction

   logic [IdxBits-1:0] m_idx_c;
   assign m_idx_c = enc(match_c);

   logic               m_any;
   logic [IdxBits-1:0] m_idx, l_idx, ins_idx;
   logic [IdxBits-1:0] mr;
   logic               ins_ok, evict;
   logic [Entries-1:0] valid_ev;

   always_comb begin
      m_any   = |match_ff;
      m_idx   = enc(match_ff);
      l_idx   = enc(lru_ff);
      mr      = rd_rank_ff;
      evict   = (occ_ff >= cap_eff) && (occ_ff != '0) && (|lru_ff);
      valid_ev = valid_ff;
      if (evict) valid_ev[l_idx] = 1'b0;
      ins_idx = enc(~valid_ev);
      ins_ok  = |(~valid_ev);
      valid_in = valid_ff;
      stale_in = stale_ff;
      for (int i = 0; i < Entries; i++) rank_in[i] = rank_ff[i];
      hits_in = hits_ff;
      miss_in = miss_ff;
      occ_in  = occ_ff;
      rsp_in  = '0;
      unique case (cmd_type'(rq_ff.cmd))
         CMD_GET: begin
            if (m_any && stale_ff[m_idx]) begin
               valid_in[m_idx] = 1'b0;
               stale_in[m_idx] = 1'b0;
               for (int i = 0; i < Entries; i++)
                  if (valid_ff[i] && rank_ff[i] > mr) rank_in[i] = rank_ff[i] - 1'b1;
               occ_in  = occ_ff - OccBits'(1);
               miss_in = (&miss_ff) ? miss_ff : miss_ff + 32'd1;
            end else if (m_any && rd_k_ff >= rq_ff.requested_k) begin
               for (int i = 0; i < Entries; i++)
                  if (valid_ff[i] && rank_ff[i] < mr) rank_in[i] = rank_ff[i] + 1'b1;
               rank_in[m_idx] = '0;
               rsp_in.hit = 1'b1;
               rsp_in.found_handle = rd_handle_ff;
               rsp_in.found_count = (rq_ff.requested_k < rd_count_ff) ?
                                    rq_ff.requested_k : rd_count_ff;
               hits_in = (&hits_ff) ? hits_ff : hits_ff + 32'd1;
            end else begin
               miss_in = (&miss_ff) ? miss_ff : miss_ff + 32'd1;
            end
         end
         CMD_PUT: begin
            if (cap_eff != '0) begin
               if (m_any) begin
                  for (int i = 0; i < Entries; i++)
                     if (valid_ff[i] && rank_ff[i] < mr) rank_in[i] = rank_ff[i] + 1'b1;
                  rank_in[m_idx] = '0;
                  stale_in[m_idx] = 1'b0;
               end else if (ins_ok) begin
                  for (int i = 0; i < Entries; i++)
                     if (valid_ev[i]) rank_in[i] = rank_ff[i] + 1'b1;
                  valid_in = valid_ev;
                  valid_in[ins_idx] = 1'b1;
                  stale_in[ins_idx] = 1'b0;
                  if (evict) stale_in[l_idx] = 1'b0;
                  rank_in[ins_idx] = '0;
                  occ_in = evict ? occ_ff : occ_ff + OccBits'(1);
               end
            end
         end
         CMD_INV: stale_in = valid_ff;
         CMD_CLR: begin
            valid_in = '0;
            stale_in = '0;
            hits_in  = '0;
            miss_in  = '0;
            occ_in   = '0;
         end
         default: ;
      endcase
      rsp_in.hit_total  = hits_in;
      rsp_in.miss_total = miss_in;
      rsp_in.occupancy  = 7'(occ_in);
   end

   logic               wr_en;
   logic [IdxBits-1:0] wr_idx;
   assign wr_en  = busy_ff && (cmd_type'(rq_ff.cmd) == CMD_PUT) && (cap_eff != '0)
                   && (m_any || ins_ok);
   assign wr_idx = m_any ? m_idx : ins_idx;
   assign sts.done = busy_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (ctl.start) rq_ff <= req_data;
      match_ff     <= match_c;
      lru_ff       <= lru_c;
      rd_k_ff      <= k_ff[m_idx_c];
      rd_handle_ff <= handle_ff[m_idx_c];
      rd_count_ff  <= count_ff[m_idx_c];
      rd_rank_ff   <= rank_ff[m_idx_c];
      if (busy_ff) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < Entries; i++) rank_ff[i] <= rank_in[i];
      end
      if (wr_en) begin
         if (!m_any) key_ff[wr_idx] <= qkey;
         k_ff[wr_idx]      <= rq_ff.requested_k;
         handle_ff[wr_idx] <= rq_ff.store_handle;
         count_ff[wr_idx]  <= rq_ff.store_count;
      end
      if (reset) begin
         cmp_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         valid_ff <= '0;
         stale_ff <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
         occ_ff   <= '0;
         cap_ff   <= 7'(Entries);
      end else begin
         cmp_ff  <= ctl.start;
         busy_ff <= cmp_ff;
         if (csr_we) cap_ff <= csr_data;
         if (busy_ff) begin
            valid_ff <= valid_in;
            stale_ff <= stale_in;
            hits_ff  <= hits_in;
            miss_ff  <= miss_in;
            occ_ff   <= occ_in;
         end
      end
   end
endmodule

// ===== sv/lru_result_cache_with_invalidation.sv =====
// lru result cache top level
//
// req channel carries one command (lookup, store, invalidate, clear).
// rsp channel returns exactly one response per request, in order.
// csr channel writes the capacity register; write only while idle.
// the request is registered first; the parallel key compare and entry
// read are registered in the match stage, then the rank update and entry
// write take place as the response is registered.
// one request is in flight at a time;
// the controller takes a new request the cycle after the response transfers.
// a stalled receiver holds the response and blocks new requests.
// reset empties the cache, zeroes the counters and sets capacity to 64.
// no clearing pass is needed after reset.
module lru_result_cache_with_invalidation import lrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);
   ctl_type ctl;
   sts_type sts;

   assign csr_ready = !reset;

   lrc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .ctl, .sts
   );

   lrc_dpath u_dpath (
      .clock, .reset, .csr_we(csr_valid), .csr_data, .req_data, .ctl, .sts, .rsp_data
   );
endmodule

// ===== sv/lrc_checker.sv =====
// port level checker for the lru result cache
`include "assert_macros.svh"
module lrc_checker import lrc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")
   `ASSERT_CLK(a_no_overlap, clock, reset, rsp_valid |-> !req_ready, "request taken while response pending")
   `ASSERT_CLK(a_lat, clock, reset, req_valid && req_ready |-> ##3 rsp_valid, "response latency wrong")
   `ASSERT_CLK(a_occ, clock, reset, rsp_valid |-> rsp_data.occupancy <= 7'(Entries), "occupancy above entries")
   `ASSERT_NORST(a_rst, clock, reset |=> !rsp_valid, "response after reset")
endmodule

bind lru_result_cache_with_invalidation lrc_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);

// ===== test/lru_result_cache_with_invalidation_test.sv =====
// testbench for the lru result cache: random and directed commands checked against a predictor
module lru_result_cache_with_invalidation_test;
   import lrc_pkg::*;

   localparam int WatchLimit = 20000;

   class cache_scoreboard;
      int unsigned cap_limit;
      bit          ent_valid [Entries];
      bit          ent_stale [Entries];
      logic [31:0] ent_key [Entries];
      logic [15:0] ent_k [Entries];
      logic [31:0] ent_handle [Entries];
      logic [15:0] ent_count [Entries];
      int unsigned ent_rank [Entries];
      logic [31:0] hits_seen;
      logic [31:0] misses_seen;
      rsp_type     pending_rsp [$];
      int unsigned mismatches;

      function new();
         cap_limit = 64;
         hits_seen = 0;
         misses_seen = 0;
         mismatches = 0;
         for (int i = 0; i < Entries; i++) begin
            ent_valid[i] = 0;
            ent_stale[i] = 0;
            ent_rank[i] = 0;
         end
      endfunction

      function int unsigned held_count();
         int unsigned n;
         n = 0;
         for (int i = 0; i < Entries; i++) if (ent_valid[i]) n++;
         return n;
      endfunction

      function int find_slot(logic [31:0] key);
         for (int i = 0; i < Entries; i++)
            if (ent_valid[i] && ent_key[i] == key) return i;
         return -1;
      endfunction

      function void promote(int slot);
         int unsigned r;
         r = ent_rank[slot];
         for (int i = 0; i < Entries; i++)
            if (ent_valid[i] && i != slot && ent_rank[i] < r) ent_rank[i]++;
         ent_rank[slot] = 0;
      endfunction

      function void drop(int slot);
         int unsigned r;
         r = ent_rank[slot];
         ent_valid[slot] = 0;
         ent_stale[slot] = 0;
         for (int i = 0; i < Entries; i++)
            if (ent_valid[i] && ent_rank[i] > r) ent_rank[i]--;
      endfunction

      function logic [31:0] sat_inc(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 1;
      endfunction

      function void note_request(req_type rq);
         rsp_type     rs;
         int          slot;
         int unsigned cap, occ;
         rs = '0;
         cap = (cap_limit > Entries) ? Entries : cap_limit;
         case (cmd_type'(rq.cmd))
            CMD_GET: begin
               slot = find_slot(rq.query_key);
               if (slot >= 0 && ent_stale[slot]) begin
                  drop(slot);
                  misses_seen = sat_inc(misses_seen);
               end else if (slot >= 0 && ent_k[slot] >= rq.requested_k) begin
                  promote(slot);
                  rs.hit = 1;
                  rs.found_handle = ent_handle[slot];
                  rs.found_count = (rq.requested_k < ent_count[slot]) ?
                     rq.requested_k : ent_count[slot];
                  hits_seen = sat_inc(hits_seen);
               end else begin
                  misses_seen = sat_inc(misses_seen);
               end
            end
            CMD_PUT: begin
               if (cap != 0) begin
                  slot = find_slot(rq.query_key);
                  if (slot < 0) begin
                     occ = held_count();
                     if (occ >= cap && occ > 0) begin
                        for (int i = 0; i < Entries; i++)
                           if (ent_valid[i] && ent_rank[i] == occ - 1) begin
                              drop(i);
                              break;
                           end
                     end
                     for (int i = 0; i < Entries; i++)
                        if (!ent_valid[i]) begin
                           slot = i;
                           break;
                        end
                     if (slot >= 0) begin
                        for (int i = 0; i < Entries; i++) if (ent_valid[i]) ent_rank[i]++;
                        ent_valid[slot] = 1;
                        ent_rank[slot] = 0;
                        ent_key[slot] = rq.query_key;
                     end
                  end else begin
                     promote(slot);
                  end
                  if (slot >= 0) begin
                     ent_stale[slot] = 0;
                     ent_k[slot] = rq.requested_k;
                     ent_handle[slot] = rq.store_handle;
                     ent_count[slot] = rq.store_count;
                  end
               end
            end
            CMD_INV: begin
               for (int i = 0; i < Entries; i++) if (ent_valid[i]) ent_stale[i] = 1;
            end
            default: begin
               for (int i = 0; i < Entries; i++) begin
                  ent_valid[i] = 0;
                  ent_stale[i] = 0;
               end
               hits_seen = 0;
               misses_seen = 0;
            end
         endcase
         rs.hit_total = hits_seen;
         rs.miss_total = misses_seen;
         rs.occupancy = 7'(held_count());
         pending_rsp.push_back(rs);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.hit !== want.hit || got.found_handle !== want.found_handle ||
             got.found_count !== want.found_count || got.hit_total !== want.hit_total ||
             got.miss_total !== want.miss_total || got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   rsp_type    rsp_data;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   cache_scoreboard sb = new();
   bit          stim_done = 0;
   bit          rsp_stall_off = 0;
   int unsigned idle_cycles = 0;
   logic [31:0] key_pool [8];

   lru_result_cache_with_invalidation dut (.*);

   always #2 clock = ~clock;

   function automatic int unsigned gap_length();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // response side: random stalls (none in one phase), check every transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (rsp_stall_off) rsp_ready <= 1;
         else rsp_ready <= (gap_length() == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(req_type rq);
      int unsigned g;
      g = gap_length();
      repeat (g + 1) @(posedge clock);
      req_valid <= 1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rq);
      req_valid <= 0;
   endtask

   task automatic write_capacity(logic [6:0] value);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.cap_limit = value;
      csr_valid <= 0;
   endtask

   function automatic req_type make_req(cmd_type c, logic [31:0] key, logic [15:0] k,
                                        logic [31:0] h, logic [15:0] n);
      req_type rq;
      rq.cmd = c;
      rq.query_key = key;
      rq.requested_k = k;
      rq.store_handle = h;
      rq.store_count = n;
      return rq;
   endfunction

   function automatic req_type random_req(int unsigned key_span);
      req_type     rq;
      int unsigned p;
      rq = make_req(CMD_GET, key_pool[$urandom_range(0, 7)] + $urandom_range(0, key_span),
                    16'($urandom_range(0, 20)), $urandom, 16'($urandom_range(0, 20)));
      if ($urandom_range(0, 9) == 0) rq.requested_k = 16'($urandom);
      if ($urandom_range(0, 9) == 0) rq.store_count = 16'($urandom);
      if ($urandom_range(0, 19) == 0) rq.query_key = $urandom;
      p = $urandom_range(0, 99);
      if (p < 50) rq.cmd = CMD_GET;
      else if (p < 92) rq.cmd = CMD_PUT;
      else if (p < 97) rq.cmd = CMD_INV;
      else rq.cmd = CMD_CLR;
      return rq;
   endfunction

   initial begin
      logic [6:0] caps [6];
      caps = '{7'd4, 7'd0, 7'd1, 7'd127, 7'd64, 7'd16};
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every command, stale and small-k cases
      send_request(make_req(CMD_GET, 32'h0, 16'h0, 32'h0, 16'h0));
      send_request(make_req(CMD_PUT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_request(make_req(CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0));
      send_request(make_req(CMD_PUT, 32'h0, 16'd5, 32'h1234_5678, 16'd3));
      send_request(make_req(CMD_GET, 32'h0, 16'd6, 32'h0, 16'h0));
      send_request(make_req(CMD_GET, 32'h0, 16'd2, 32'h0, 16'h0));
      send_request(make_req(CMD_INV, 32'h0, 16'h0, 32'h0, 16'h0));
      send_request(make_req(CMD_PUT, 32'h0, 16'd9, 32'hA5A5_A5A5, 16'd9));
      send_request(make_req(CMD_GET, 32'h0, 16'd9, 32'hFFFF_FFFF, 16'hFFFF));
      send_request(make_req(CMD_GET, 32'hFFFF_FFFF, 16'd1, 32'h0, 16'h0));
      send_request(make_req(CMD_CLR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      write_capacity(7'd2);
      for (int i = 0; i < 4; i++)
         send_request(make_req(CMD_PUT, 32'(i), 16'd4, 32'(i + 100), 16'd4));
      send_request(make_req(CMD_GET, 32'd2, 16'd4, 32'h0, 16'h0));
      write_capacity(7'd1);
      send_request(make_req(CMD_PUT, 32'd9, 16'd4, 32'd9, 16'd4));
      send_request(make_req(CMD_GET, 32'd3, 16'd4, 32'h0, 16'h0));
      // random phases across capacity settings
      foreach (caps[c]) begin
         write_capacity(caps[c]);
         rsp_stall_off = (c == 3);
         for (int i = 0; i < 80; i++) send_request(random_req(caps[c] > 8 ? 40 : 3));
      end
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
